// File: rtl/assert_macros.svh
// Assertion macros shared by the reset frame builder RTL.
// Active in simulation; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check on clk, ignored while rst_n is low.
`define RFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on clk, also evaluated during reset.
`define RFB_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RFB_ASSERT(lbl, prop, msg)
`define RFB_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// File: rtl/rfb_pkg.sv
// Package for the TCP reset frame builder: payload structs, frame constants,
// checksum seeds and the ip identification LFSR step. No dependencies.
`timescale 1ns / 1ps

package rfb_pkg;

  localparam int FrameLen      = 54;
  localparam int CntW          = 6;
  localparam int AccW          = 20;
  localparam int SumSteps      = 8;   // emitted bytes that add a header word
  localparam int FoldDone      = 10;  // ends the fold steps that follow the adds
  localparam int RfbQueueDepth = 2;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  IpVerIhl      = 8'h45;
  localparam logic [7:0]  IpTos         = 8'h00;
  localparam logic [15:0] IpTotalLen    = 16'd40;
  localparam logic [15:0] IpFlagsFrag   = 16'h4000;
  localparam logic [7:0]  IpTtl         = 8'hFF;
  localparam logic [7:0]  IpProtoTcp    = 8'd6;
  localparam logic [7:0]  TcpDataOff    = 8'h50;
  localparam logic [7:0]  TcpFlagsRst   = 8'h04;
  localparam logic [15:0] TcpLen        = 16'd20;
  localparam logic [15:0] LfsrSeed      = 16'hACE1;

  // Constant words of each checksum, summed at elaboration.
  localparam logic [AccW-1:0] IpSumInit =
    AccW'({IpVerIhl, IpTos}) + AccW'(IpTotalLen) + AccW'(IpFlagsFrag) +
    AccW'({IpTtl, IpProtoTcp});
  localparam logic [AccW-1:0] TcpSumInit =
    AccW'(IpProtoTcp) + AccW'(TcpLen) + AccW'({TcpDataOff, TcpFlagsRst});

  typedef struct packed {
    logic [47:0] client_mac;
    logic [47:0] endpoint_mac;
    logic        endpoint_known;
    logic [31:0] client_ip;
    logic [31:0] server_ip;
    logic [15:0] client_port;
    logic [15:0] server_port;
    logic [31:0] client_next_seq;
    logic [31:0] server_next_seq;
    logic        ingress;
    logic        toward_server;
    logic        passive;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_item_t;

  // Resolved frame descriptor passed from front to back.
  typedef struct packed {
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq;
    logic [15:0] ip_id;
  } desc_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[15:1]};
  endfunction

endpackage

// File: rtl/rfb_front.sv
// Front end: accepts sessions, drops passive or unknown-endpoint ones,
// resolves direction and stamps the ip id. Depends on rfb_pkg.
`timescale 1ns / 1ps

module rfb_front import rfb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     q_push,
  output desc_t    q_wr
);

  logic [15:0] lfsr_r, lfsr_nxt;
  logic        keep;
  logic        mac_swap;

  assign in_stall = q_stat.full;
  assign keep     = in_data.endpoint_known && !in_data.passive;
  assign q_push   = in_valid && !in_stall && keep;
  assign mac_swap = in_data.ingress != in_data.toward_server;
  assign lfsr_nxt = lfsr_next(lfsr_r);

  always_comb begin
    q_wr.dst_mac  = mac_swap ? in_data.client_mac : in_data.endpoint_mac;
    q_wr.src_mac  = mac_swap ? in_data.endpoint_mac : in_data.client_mac;
    q_wr.src_ip   = in_data.toward_server ? in_data.client_ip : in_data.server_ip;
    q_wr.dst_ip   = in_data.toward_server ? in_data.server_ip : in_data.client_ip;
    q_wr.src_port = in_data.toward_server ? in_data.client_port : in_data.server_port;
    q_wr.dst_port = in_data.toward_server ? in_data.server_port : in_data.client_port;
    q_wr.seq      = in_data.toward_server ? in_data.client_next_seq : in_data.server_next_seq;
    q_wr.ip_id    = lfsr_nxt;
  end

  // Advance only for frames that will be sent.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= LfsrSeed;
    end else if (q_push) begin
      lfsr_r <= lfsr_nxt;
    end
  end

endmodule

// File: rtl/rfb_queue.sv
// Short descriptor queue between front and back ends.
// Depends on rfb_pkg for desc_t and q_stat_t.
`timescale 1ns / 1ps

module rfb_queue import rfb_pkg::*; #(
  parameter int Depth = RfbQueueDepth
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_push,
  input  desc_t   q_wr,
  input  logic    q_pop,
  output desc_t   q_rd,
  output q_stat_t q_stat
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntQW = $clog2(Depth + 1);

  desc_t             mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntQW-1:0]  count_r, count_nxt;

  assign q_rd         = mem_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CntQW'(Depth));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (q_pop && !q_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_wr;
    end
  end

endmodule

// File: rtl/rfb_back.sv
// Back end: serializes one descriptor into 54 frame bytes and folds both
// checksums while the header bytes go out. Depends on rfb_pkg.
`timescale 1ns / 1ps

module rfb_back import rfb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  desc_t     q_rd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  desc_t                desc_r;
  logic                 active_r, active_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic [AccW-1:0]      ip_acc_r, ip_acc_nxt;
  logic [AccW-1:0]      tcp_acc_r, tcp_acc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r;
  logic                 emit;
  logic                 last;
  logic                 load;
  logic [15:0]          ip_word;
  logic [15:0]          tcp_word;
  logic [FrameLen*8-1:0] frame_w;
  logic [7:0]           byte_sel;

  assign emit  = active_r && (!out_valid_r || !out_stall);
  assign last  = (cnt_r == CntW'(FrameLen - 1));
  assign load  = !q_stat.empty && (!active_r || (emit && last));
  assign q_pop = load;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // One header word per emitted byte during the first cycles.
  always_comb begin
    ip_word  = '0;
    tcp_word = '0;
    case (cnt_r)
      CntW'(0): begin ip_word = desc_r.src_ip[31:16]; tcp_word = desc_r.src_ip[31:16]; end
      CntW'(1): begin ip_word = desc_r.src_ip[15:0];  tcp_word = desc_r.src_ip[15:0];  end
      CntW'(2): begin ip_word = desc_r.dst_ip[31:16]; tcp_word = desc_r.dst_ip[31:16]; end
      CntW'(3): begin ip_word = desc_r.dst_ip[15:0];  tcp_word = desc_r.dst_ip[15:0];  end
      CntW'(4): begin ip_word = desc_r.ip_id;         tcp_word = desc_r.src_port;      end
      CntW'(5): tcp_word = desc_r.dst_port;
      CntW'(6): tcp_word = desc_r.seq[31:16];
      CntW'(7): tcp_word = desc_r.seq[15:0];
      default: begin
        ip_word  = '0;
        tcp_word = '0;
      end
    endcase
  end

  always_comb begin
    frame_w = {desc_r.dst_mac, desc_r.src_mac, EtherTypeIpv4,
               IpVerIhl, IpTos, IpTotalLen, desc_r.ip_id, IpFlagsFrag,
               IpTtl, IpProtoTcp, ~ip_acc_r[15:0], desc_r.src_ip, desc_r.dst_ip,
               desc_r.src_port, desc_r.dst_port, desc_r.seq, 32'h0,
               TcpDataOff, TcpFlagsRst, 16'h0, ~tcp_acc_r[15:0], 16'h0};
    byte_sel = frame_w[{CntW'(FrameLen - 1) - cnt_r, 3'b000} +: 8];
  end

  always_comb begin
    active_nxt    = active_r;
    cnt_nxt       = cnt_r;
    ip_acc_nxt    = ip_acc_r;
    tcp_acc_nxt   = tcp_acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt = 1'b1;
      cnt_nxt       = cnt_r + 1'b1;
      if (cnt_r < CntW'(SumSteps)) begin
        ip_acc_nxt  = ip_acc_r + AccW'(ip_word);
        tcp_acc_nxt = tcp_acc_r + AccW'(tcp_word);
      end else if (cnt_r < CntW'(FoldDone)) begin
        // End-around carry fold
        ip_acc_nxt  = AccW'(ip_acc_r[15:0]) + AccW'(ip_acc_r[AccW-1:16]);
        tcp_acc_nxt = AccW'(tcp_acc_r[15:0]) + AccW'(tcp_acc_r[AccW-1:16]);
      end
      if (last) begin
        active_nxt = 1'b0;
      end
    end
    if (load) begin
      active_nxt  = 1'b1;
      cnt_nxt     = '0;
      ip_acc_nxt  = IpSumInit;
      tcp_acc_nxt = TcpSumInit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ip_acc_r  <= ip_acc_nxt;
    tcp_acc_r <= tcp_acc_nxt;
    if (load) begin
      desc_r <= q_rd;
    end
    if (emit) begin
      out_data_r.frame_byte <= byte_sel;
      out_data_r.last_byte  <= last;
    end
  end

endmodule

// File: rtl/tcp_reset_frame_builder_top.sv
// Top level of the TCP reset frame builder: front end, descriptor queue,
// back end. Depends on rfb_pkg, rfb_front, rfb_queue, rfb_back, assert_macros.svh.
// Usage:
//   in_valid/in_stall/in_data carry one session descriptor per item. Items with
//   passive set or endpoint_known clear are taken and dropped without output.
//   out_valid/out_stall/out_data carry the 54-byte Ethernet/IPv4/TCP RST frame,
//   one byte per item in wire order, last_byte set on the final byte.
//   When the back end is idle, an accepted session passes the queue entry, the
//   back-end descriptor register and the output register before its first byte
//   is valid. The back end emits one byte per cycle unless out_stall holds it and
//   loads the next queued descriptor with the last byte, so frames follow with
//   no gap. The front end keeps accepting while the queue (QueueDepth entries)
//   has room; in_stall rises only when the queue is full. Checksums are summed
//   and folded in the back end over the first ten bytes of each frame, one
//   header word per byte. out_stall holds the output register and freezes the
//   back end; the queue still fills until full.
//   Reset (rst_n low, synchronous) empties the queue, drops any frame in flight
//   and reloads the ip identification LFSR with its seed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcp_reset_frame_builder_top import rfb_pkg::*; #(
  parameter int QueueDepth = RfbQueueDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  desc_t   q_wr;
  desc_t   q_rd;

  rfb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wr     (q_wr)
  );

  rfb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_wr   (q_wr),
    .q_pop  (q_pop),
    .q_rd   (q_rd),
    .q_stat (q_stat)
  );

  rfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rd      (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `RFB_ASSERT(a_pop_nonempty, q_pop |-> !q_stat.empty, "pop from empty queue")
  `RFB_ASSERT(a_push_not_full, q_push |-> !q_stat.full, "push into full queue")
  `RFB_ASSERT(a_id_nonzero, q_push |-> (q_wr.ip_id != 16'h0000), "ip id lfsr hit zero")
  `RFB_ASSERT_NR(a_reset_idle, !rst_n |=> !out_valid, "output valid after reset")

endmodule

// File: test/tcp_reset_frame_builder_top_tb.sv
// Testbench for tcp_reset_frame_builder_top: offers session descriptors, predicts each
// RST frame byte by byte and checks the byte stream. Depends on rfb_pkg and the RTL.
`timescale 1ns / 1ps

module tcp_reset_frame_builder_top_tb import rfb_pkg::*; ();

  localparam int RstFrameBytes = 54;

  localparam logic [15:0] EthIpv4Type  = 16'h0800;
  localparam logic [15:0] IpVerTos     = 16'h4500;
  localparam logic [15:0] IpLen        = 16'd40;
  localparam logic [15:0] IpDontFrag   = 16'h4000;
  localparam logic [15:0] IpTtlProto   = 16'hFF06;
  localparam logic [15:0] PseudoProto  = 16'd6;
  localparam logic [15:0] TcpHdrLen    = 16'd20;
  localparam logic [15:0] TcpOffRst    = 16'h5004;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  logic [15:0] ip_id_model;
  out_item_t   frame_q[$];
  int          mismatches;
  int          byte_pos;
  int          hold_request;
  rx_mode_e    rx_mode;

  tcp_reset_frame_builder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic [15:0] csum_fold(input logic [31:0] acc);
    while (acc[31:16] != 16'h0) begin
      acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    end
    return ~acc[15:0];
  endfunction

  // Build the expected frame for one accepted session and queue its bytes.
  function automatic void predict_frame(input in_item_t s);
    logic [431:0] frame;
    logic [47:0]  src_mac, dst_mac;
    logic [31:0]  src_ip, dst_ip, seq, acc;
    logic [15:0]  src_port, dst_port, ip_csum, tcp_csum;
    logic         fb;
    out_item_t    b;
    int           i;
    if (s.passive || !s.endpoint_known) return;
    fb = ip_id_model[0] ^ ip_id_model[2] ^ ip_id_model[3] ^ ip_id_model[5];
    ip_id_model = {fb, ip_id_model[15:1]};
    if (s.ingress == s.toward_server) begin
      dst_mac = s.endpoint_mac;
      src_mac = s.client_mac;
    end else begin
      dst_mac = s.client_mac;
      src_mac = s.endpoint_mac;
    end
    src_ip   = s.toward_server ? s.client_ip : s.server_ip;
    dst_ip   = s.toward_server ? s.server_ip : s.client_ip;
    src_port = s.toward_server ? s.client_port : s.server_port;
    dst_port = s.toward_server ? s.server_port : s.client_port;
    seq      = s.toward_server ? s.client_next_seq : s.server_next_seq;
    acc = 32'(IpVerTos) + 32'(IpLen) + 32'(ip_id_model) + 32'(IpDontFrag) +
          32'(IpTtlProto) + 32'(src_ip[31:16]) + 32'(src_ip[15:0]) +
          32'(dst_ip[31:16]) + 32'(dst_ip[15:0]);
    ip_csum = csum_fold(acc);
    acc = 32'(src_ip[31:16]) + 32'(src_ip[15:0]) + 32'(dst_ip[31:16]) +
          32'(dst_ip[15:0]) + 32'(PseudoProto) + 32'(TcpHdrLen) + 32'(src_port) +
          32'(dst_port) + 32'(seq[31:16]) + 32'(seq[15:0]) + 32'(TcpOffRst);
    tcp_csum = csum_fold(acc);
    frame = {dst_mac, src_mac, EthIpv4Type,
             IpVerTos, IpLen, ip_id_model, IpDontFrag, IpTtlProto, ip_csum, src_ip, dst_ip,
             src_port, dst_port, seq, 32'h0, TcpOffRst, 16'h0, tcp_csum, 16'h0};
    for (i = 0; i < RstFrameBytes; i++) begin
      b.frame_byte = frame[431 - 8 * i -: 8];
      b.last_byte  = (i == RstFrameBytes - 1);
      frame_q.push_back(b);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b",
                                  out_data.frame_byte, out_data.last_byte));
      end else begin
        want = frame_q.pop_front();
        if (out_data.frame_byte !== want.frame_byte)
          report_mismatch($sformatf("byte %0d got %02h want %02h", byte_pos,
                                    out_data.frame_byte, want.frame_byte));
        if (out_data.last_byte !== want.last_byte)
          report_mismatch($sformatf("byte %0d last got %0b want %0b", byte_pos,
                                    out_data.last_byte, want.last_byte));
        byte_pos = want.last_byte ? 0 : byte_pos + 1;
      end
    end
  end

  // Receiver: a long hold when requested, else the current stall pattern.
  initial begin
    int phase;
    out_stall = 1'b0;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if (hold_request > 0) begin
        out_stall = 1'b1;
        repeat (hold_request - 1) @(negedge clk);
        hold_request = 0;
      end else begin
        case (rx_mode)
          RX_FREE:   out_stall = 1'b0;
          RX_RANDOM: out_stall = ($urandom_range(0, 99) < 35);
          default:   out_stall = ((phase % 11) < 4);
        endcase
      end
    end
  end

  // Offer one session from a falling edge; return at the falling edge after accept.
  task automatic send_session(input in_item_t s);
    in_valid = 1'b1;
    in_data  = s;
    do @(posedge clk); while (in_stall);
    predict_frame(s);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand_field();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_item_t random_session();
    in_item_t s;
    s.client_mac      = 48'(rand_field());
    s.endpoint_mac    = 48'(rand_field());
    s.client_ip       = 32'(rand_field());
    s.server_ip       = 32'(rand_field());
    s.client_port     = 16'(rand_field());
    s.server_port     = 16'(rand_field());
    s.client_next_seq = 32'(rand_field());
    s.server_next_seq = 32'(rand_field());
    s.ingress         = 1'($urandom_range(0, 1));
    s.toward_server   = 1'($urandom_range(0, 1));
    s.passive         = ($urandom_range(0, 9) == 0);
    s.endpoint_known  = ($urandom_range(0, 9) != 0);
    return s;
  endfunction

  function automatic in_item_t base_session();
    in_item_t s;
    s.client_mac      = 48'h02_11_22_33_44_55;
    s.endpoint_mac    = 48'hA6_5B_C4_0D_E2_F9;
    s.endpoint_known  = 1'b1;
    s.client_ip       = 32'hC0A8_0A05;
    s.server_ip       = 32'h0A00_01FE;
    s.client_port     = 16'hD431;
    s.server_port     = 16'd443;
    s.client_next_seq = 32'h8BAD_F00D;
    s.server_next_seq = 32'h1234_5678;
    s.ingress         = 1'b0;
    s.toward_server   = 1'b0;
    s.passive         = 1'b0;
    return s;
  endfunction

  task automatic test_directed_sessions();
    in_item_t s;
    int       k;
    rx_mode = RX_FREE;
    s = '0;
    s.endpoint_known = 1'b1;
    send_session(s);
    s = '1;
    s.passive = 1'b0;
    send_session(s);
    // every ingress / direction pairing
    for (k = 0; k < 4; k++) begin
      s = base_session();
      s.ingress       = k[0];
      s.toward_server = k[1];
      send_session(s);
    end
    // tap/proxy sessions and unknown endpoints give no frame
    s = base_session();
    s.passive = 1'b1;
    send_session(s);
    s = base_session();
    s.endpoint_known = 1'b0;
    send_session(s);
    s = base_session();
    s.passive = 1'b1;
    s.endpoint_known = 1'b0;
    send_session(s);
    // TCP sum folds to all ones, so the checksum goes out as zero
    s = '0;
    s.endpoint_known = 1'b1;
    s.toward_server = 1'b1;
    s.client_port = 16'hFFFF - TcpOffRst - PseudoProto - TcpHdrLen;
    send_session(s);
    s = base_session();
    s.toward_server = 1'b1;
    s.client_ip = '1;
    s.server_ip = '1;
    s.client_next_seq = '1;
    s.client_port = '0;
    s.server_port = '1;
    send_session(s);
    s = base_session();
    s.client_ip = '0;
    s.server_ip = '0;
    s.server_next_seq = '0;
    s.server_port = '0;
    s.client_port = '1;
    send_session(s);
    wait_drained();
  endtask

  // Hold the receiver off while the sender keeps offering, so the input stalls.
  task automatic test_receiver_holdoff();
    in_item_t s;
    int       k;
    rx_mode = RX_FREE;
    hold_request = 400;
    for (k = 0; k < 8; k++) begin
      s = random_session();
      s.passive        = 1'b0;
      s.endpoint_known = 1'b1;
      send_session(s);
    end
    wait_drained();
  endtask

  task automatic test_random_sessions(input int items, input rx_mode_e mode,
                                      input bit idles);
    in_item_t s;
    int       sent, burst_left, gap;
    rx_mode = mode;
    sent = 0;
    burst_left = 0;
    while (sent < items) begin
      s = random_session();
      if (idles && burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 10);
      end
      send_session(s);
      if (burst_left > 0) burst_left--;
      sent++;
    end
    wait_drained();
  endtask

  initial begin
    mismatches   = 0;
    byte_pos     = 0;
    hold_request = 0;
    rx_mode      = RX_FREE;
    ip_id_model  = 16'hACE1;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_sessions();
    test_receiver_holdoff();
    test_random_sessions(110, RX_FREE, 1'b1);
    test_random_sessions(110, RX_RANDOM, 1'b1);
    test_random_sessions(110, RX_PERIODIC, 1'b0);
    test_random_sessions(110, RX_RANDOM, 1'b0);

    rx_mode = RX_FREE;
    wait_drained();
    repeat (64) @(posedge clk);
    if (frame_q.size() != 0)
      report_mismatch($sformatf("%0d bytes never arrived", frame_q.size()));
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rfb_pkg.sv
rtl/rfb_front.sv
rtl/rfb_queue.sv
rtl/rfb_back.sv
rtl/tcp_reset_frame_builder_top.sv
test/tcp_reset_frame_builder_top_tb.sv
